FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, sampled on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/xbrle_pkg.sv
// ----------------------------------------------------------------------------
// xbrle_pkg
// shared types and constants of the run-length cell decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package xbrle_pkg;

  localparam int MaxRun   = 64;
  localparam int RemW     = $clog2(MaxRun) + 1;
  localparam int CellCntW = 32;

  // configuration register indexes
  localparam logic [1:0] CFG_COMPRESSED   = 2'd0;
  localparam logic [1:0] CFG_LIMIT_ENABLE = 2'd1;
  localparam logic [1:0] CFG_CELL_LIMIT   = 2'd2;

  // decode phases
  localparam logic [1:0] PH_CODE = 2'd0;
  localparam logic [1:0] PH_OPER = 2'd1;
  localparam logic [1:0] PH_CELL = 2'd2;
  localparam logic [1:0] PH_BAD  = 2'd3;

  // run kinds from bits 7..6 of a code byte
  localparam logic [1:0] KIND_LIT  = 2'd0;
  localparam logic [1:0] KIND_CHAR = 2'd1;
  localparam logic [1:0] KIND_ATTR = 2'd2;
  localparam logic [1:0] KIND_BOTH = 2'd3;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_BURST
  } state_t;

  typedef struct packed {
    logic take_item;
    logic burst_emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic burst_start;
    logic burst_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/xbrle_ctrl.sv
// ----------------------------------------------------------------------------
// xbrle_ctrl
// sequencer: takes words in idle, drives repeated-cell bursts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xbrle_ctrl
  import xbrle_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire dp_stat_t   stat,
  output      ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && stat.out_free && stat.burst_start) begin
          state_next = ST_BURST;
        end
      end
      ST_BURST: begin
        if (stat.out_free && stat.burst_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd.take_item  = 1'b0;
    cmd.burst_emit = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready      = stat.out_free;
        cmd.take_item = in_valid && stat.out_free;
      end
      ST_BURST: begin
        cmd.burst_emit = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/xbrle_dp.sv
// ----------------------------------------------------------------------------
// xbrle_dp
// decode state, configuration, cell counter and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module xbrle_dp
  import xbrle_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [CellCntW-1:0] cfg_data,
  input  wire logic                in_start,
  input  wire logic [7:0]          in_byte,
  input  wire ctrl_cmd_t           cmd,
  output      dp_stat_t            stat,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      logic [7:0]          out_char,
  output      logic [7:0]          out_attr,
  output      logic                out_last
);

  logic                compressed;
  logic                limit_enable;
  logic [CellCntW-1:0] cell_limit;

  logic [1:0]          phase;
  logic [1:0]          run_kind;
  logic [RemW-1:0]     run_remaining;
  logic [7:0]          held_byte;
  logic [7:0]          pending_char;
  logic [CellCntW-1:0] cells_done;
  logic [7:0]          burst_attr;

  // state seen by the word after an optional start clear
  logic [1:0]          ph;
  logic [1:0]          kind;
  logic [RemW-1:0]     rem;
  logic [7:0]          held;
  logic [7:0]          pend;
  logic [CellCntW-1:0] cd;
  logic [1:0]          phe;
  logic                at_limit;

  logic [1:0]          phase_next;
  logic [1:0]          run_kind_next;
  logic [RemW-1:0]     run_remaining_next;
  logic [7:0]          held_byte_next;
  logic [7:0]          pending_char_next;
  logic                emit;
  logic [7:0]          emit_char;
  logic [7:0]          emit_attr;
  logic                burst_start;
  logic [CellCntW-1:0] cd_inc;
  logic [CellCntW-1:0] done_inc;
  logic                load;

  always_comb begin
    ph       = in_start ? PH_CODE : phase;
    kind     = in_start ? KIND_LIT : run_kind;
    rem      = in_start ? '0 : run_remaining;
    held     = in_start ? 8'h00 : held_byte;
    pend     = in_start ? 8'h00 : pending_char;
    cd       = in_start ? '0 : cells_done;
    at_limit = limit_enable && (cd >= cell_limit);
    cd_inc   = (cd == '1) ? cd : cd + 1'b1;
  end

  always_comb begin
    phe = ((ph == PH_BAD) || ((ph != PH_CODE) && (rem == '0))) ? PH_CODE : ph;
  end

  always_comb begin
    phase_next         = ph;
    run_kind_next      = kind;
    run_remaining_next = rem;
    held_byte_next     = held;
    pending_char_next  = pend;
    emit               = 1'b0;
    emit_char          = pend;
    emit_attr          = in_byte;
    burst_start        = 1'b0;
    if (!compressed) begin
      run_remaining_next = '0;
      if (ph == PH_OPER) begin
        phase_next = PH_CODE;
        emit       = !at_limit;
      end else begin
        pending_char_next = in_byte;
        phase_next        = PH_OPER;
      end
    end else begin
      phase_next = phe;
      unique case (phe)
        PH_CODE: begin
          // a code byte is dropped once the cell count has reached the limit
          if (!at_limit) begin
            run_kind_next      = in_byte[7:6];
            run_remaining_next = {1'b0, in_byte[5:0]} + 1'b1;
            phase_next         = PH_OPER;
          end
        end
        PH_OPER: begin
          if (kind == KIND_LIT) begin
            pending_char_next = in_byte;
          end else begin
            held_byte_next = in_byte;
          end
          phase_next = PH_CELL;
        end
        PH_CELL: begin
          run_remaining_next = rem - 1'b1;
          unique case (kind)
            KIND_LIT: begin
              emit       = 1'b1;
              phase_next = (rem == 1) ? PH_CODE : PH_OPER;
            end
            KIND_CHAR: begin
              emit       = 1'b1;
              emit_char  = held;
              phase_next = (rem == 1) ? PH_CODE : PH_CELL;
            end
            KIND_ATTR: begin
              emit       = 1'b1;
              emit_char  = in_byte;
              emit_attr  = held;
              phase_next = (rem == 1) ? PH_CODE : PH_CELL;
            end
            default: begin
              // whole run leaves through the burst sequence
              run_remaining_next = rem;
              burst_start        = 1'b1;
              phase_next         = PH_CODE;
            end
          endcase
        end
        default: phase_next = PH_CODE;
      endcase
    end
  end

  assign done_inc = (cells_done == '1) ? cells_done : cells_done + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      compressed   <= 1'b0;
      limit_enable <= 1'b0;
      cell_limit   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COMPRESSED:   compressed   <= cfg_data[0];
        CFG_LIMIT_ENABLE: limit_enable <= cfg_data[0];
        CFG_CELL_LIMIT:   cell_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_CODE;
      run_kind      <= KIND_LIT;
      run_remaining <= '0;
      held_byte     <= 8'h00;
      pending_char  <= 8'h00;
      cells_done    <= '0;
    end else if (cmd.take_item) begin
      phase         <= phase_next;
      run_kind      <= run_kind_next;
      run_remaining <= run_remaining_next;
      held_byte     <= held_byte_next;
      pending_char  <= pending_char_next;
      cells_done    <= emit ? cd_inc : cd;
    end else if (cmd.burst_emit) begin
      run_remaining <= run_remaining - 1'b1;
      cells_done    <= done_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item && burst_start) begin
      burst_attr <= in_byte;
    end
  end

  assign load = (cmd.take_item && emit) || cmd.burst_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.burst_emit) begin
      out_char <= held_byte;
      out_attr <= burst_attr;
      out_last <= (run_remaining == 1);
    end else if (load) begin
      out_char <= emit_char;
      out_attr <= emit_attr;
      out_last <= 1'b1;
    end
  end

  always_comb begin
    stat.burst_start = burst_start;
    stat.burst_last  = (run_remaining == 1);
    stat.out_free    = !out_valid || out_ready;
  end

  `AST_IMP(a_burst_nonempty, cmd.burst_emit, run_remaining != '0, "burst with empty run")
  `AST_IMP(a_no_overwrite, load, !out_valid || out_ready, "output cell overwritten")
  `AST_NXT(a_count_mono, !cmd.take_item, cells_done >= $past(cells_done), "cell count fell")

endmodule

`default_nettype wire

FILE: rtl/core/xbin_rle_cell_decoder_top.sv
// output: a cell is registered in the output register as its byte is taken
// throughput: one byte per cycle while the output is drained; a both-repeated run
//   holds the input while its cells (1..64) leave the output register
// reset: rst synchronous active high clears configuration, decode state,
//   cell counter and the output valid flag
// ----------------------------------------------------------------------------
// xbin_rle_cell_decoder_top
// run-length decoder of text-mode image data into char/attribute cells
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xbin_rle_cell_decoder_top
  import xbrle_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // configuration writes, index 0 compressed, 1 limit_enable, 2 cell_limit
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [CellCntW-1:0] cfg_data,
  // input byte stream
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,  // [7:0] data_byte
  input  wire logic                s_axis_tuser,  // [0] start_req
  // decoded cells
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output      logic [15:0]         m_axis_tdata,  // [7:0] char_code, [15:8] attribute
  output      logic                m_axis_tlast   // last cell caused by a word
);

  ctrl_cmd_t  cmd;
  dp_stat_t   stat;
  logic [7:0] out_char;
  logic [7:0] out_attr;

  // sequencer: accepts a word in idle when the output slot is free, runs bursts
  xbrle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // decode state, counter against the cell limit, and the output register
  xbrle_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_start  (s_axis_tuser),
    .in_byte   (s_axis_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_char  (out_char),
    .out_attr  (out_attr),
    .out_last  (m_axis_tlast)
  );

  // char in the low byte, attribute above it
  assign m_axis_tdata = {out_attr, out_char};

endmodule

`default_nettype wire

FILE: tb/rle_cell_checker.sv
// ----------------------------------------------------------------------------
// rle_cell_checker
// watches the byte, cell and configuration channels of the run-length cell
// decoder, predicts the cells of every accepted byte and compares each
// accepted cell with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rle_cell_checker
  import xbrle_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CellCntW-1:0] cfg_data,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [7:0] data_byte
  input  logic                s_axis_tuser,  // [0] start_req
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [15:0]         m_axis_tdata,  // [7:0] char_code, [15:8] attribute
  input  logic                m_axis_tlast,
  output int                  mismatches,
  output int                  cells_owed
);

  typedef struct packed {
    logic [7:0] chr;
    logic [7:0] attr;
    logic       fin;
  } cell_t;

  cell_t expected_cells[$];

  // mirrored registers
  logic                rle_mode;
  logic                limit_on;
  logic [CellCntW-1:0] limit_cells;

  // mirrored decode state
  logic [1:0]          phase;
  logic [1:0]          kind;
  logic [RemW-1:0]     run_left;
  logic [7:0]          held;
  logic [7:0]          pend_char;
  logic [CellCntW-1:0] cells_done;

  int bad_cells = 0;

  function automatic logic limit_hit();
    return limit_on && (cells_done >= limit_cells);
  endfunction

  task automatic clear_decode();
    phase      = PH_CODE;
    kind       = KIND_LIT;
    run_left   = '0;
    held       = '0;
    pend_char  = '0;
    cells_done = '0;
  endtask

  task automatic emit_cell(input logic [7:0] chr, input logic [7:0] attr, input logic fin);
    cell_t c;
    c.chr  = chr;
    c.attr = attr;
    c.fin  = fin;
    expected_cells.push_back(c);
    if (cells_done != '1) cells_done = cells_done + 1'b1;
  endtask

  task automatic decode_byte(input logic start, input logic [7:0] b);
    if (start) clear_decode();
    if (!rle_mode) begin
      // plain pairs: char word, then attribute word
      run_left = '0;
      if (phase == PH_OPER) begin
        if (!limit_hit()) emit_cell(pend_char, b, 1'b1);
        phase = PH_CODE;
      end else begin
        pend_char = b;
        phase     = PH_OPER;
      end
    end else begin
      if (phase == PH_BAD || (phase != PH_CODE && run_left == 0)) phase = PH_CODE;
      if (phase == PH_CODE) begin
        // code words are dropped once the limit is reached
        if (!limit_hit()) begin
          kind     = b[7:6];
          run_left = {1'b0, b[5:0]} + 1'b1;
          phase    = PH_OPER;
        end
      end else if (phase == PH_OPER) begin
        if (kind == KIND_LIT) pend_char = b;
        else held = b;
        phase = PH_CELL;
      end else begin
        case (kind)
          KIND_LIT: begin
            run_left = run_left - 1'b1;
            emit_cell(pend_char, b, 1'b1);
            phase = (run_left == 0) ? PH_CODE : PH_OPER;
          end
          KIND_CHAR: begin
            run_left = run_left - 1'b1;
            emit_cell(held, b, 1'b1);
            if (run_left == 0) phase = PH_CODE;
          end
          KIND_ATTR: begin
            run_left = run_left - 1'b1;
            emit_cell(b, held, 1'b1);
            if (run_left == 0) phase = PH_CODE;
          end
          default: begin
            while (run_left != 0) begin
              run_left = run_left - 1'b1;
              emit_cell(held, b, run_left == 0);
            end
            phase = PH_CODE;
          end
        endcase
      end
    end
  endtask

  task automatic check_cell();
    cell_t want;
    if (expected_cells.size() == 0) begin
      $display("%0t: unexpected cell char %02h attr %02h last %0b", $time,
               m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tlast);
      bad_cells++;
    end else begin
      want = expected_cells.pop_front();
      if (want.chr != m_axis_tdata[7:0] || want.attr != m_axis_tdata[15:8] ||
          want.fin != m_axis_tlast) begin
        $display("%0t: cell mismatch, expected %02h/%02h/%0b, got %02h/%02h/%0b",
                 $time, want.chr, want.attr, want.fin,
                 m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tlast);
        bad_cells++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rle_mode    = 1'b0;
      limit_on    = 1'b0;
      limit_cells = '0;
      clear_decode();
      expected_cells.delete();
    end else begin
      // cells out first so a word taken on the same edge cannot hide a stray cell
      if (m_axis_tvalid && m_axis_tready) check_cell();
      if (cfg_we) begin
        case (cfg_index)
          CFG_COMPRESSED:   rle_mode    = cfg_data[0];
          CFG_LIMIT_ENABLE: limit_on    = cfg_data[0];
          CFG_CELL_LIMIT:   limit_cells = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tuser, s_axis_tdata);
    end
    cells_owed <= expected_cells.size();
    mismatches <= bad_cells;
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives image-data words into the run-length cell decoder under random
// idling on both sides and several register settings; the checker beside
// the block predicts every cell and counts mismatches for the verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import xbrle_pkg::*;

  // cycles to let the block settle once the last cell has arrived
  localparam int SETTLE    = 8;
  // long receiver hold-off, in cycles
  localparam int LONG_HOLD = 300;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [1:0]          cfg_index;
  logic [CellCntW-1:0] cfg_data;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;   // [7:0] data_byte
  logic                s_axis_tuser;   // [0] start_req
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [15:0]         m_axis_tdata;   // [7:0] char_code, [15:8] attribute
  logic                m_axis_tlast;

  int   mismatches;
  int   cells_owed;
  int   words_sent = 0;
  // idling on/off for both sides
  logic gaps_on    = 1'b1;
  // request from the stimulus for one long receiver hold-off
  logic long_hold  = 1'b0;

  xbin_rle_cell_decoder_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  rle_cell_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .mismatches    (mismatches),
    .cells_owed    (cells_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hang guard, far above the slowest correct run
  initial begin
    #10_000_000;
    $display("testbench: errors");
    $finish;
  end

  // idle length: mostly none or short, now and then long
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (!gaps_on) return 0;
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // a start request now and then, to break runs in the middle
  function automatic logic rare_start();
    return $urandom_range(0, 99) < 3;
  endfunction

  // random data word
  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // receiver: ready bursts and stalls, plus one long hold-off on request
  initial begin : sink
    int stall_left;
    int ready_left;
    stall_left = 0;
    ready_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold  = 1'b0;
        stall_left = LONG_HOLD;
        ready_left = 0;
      end
      if (stall_left == 0 && ready_left == 0) begin
        stall_left = gap_len();
        ready_left = $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        ready_left--;
      end
    end
  end

  // offer one word and hold it until taken; valid stays high for a back-to-back word
  task automatic send_byte(input logic start, input logic [7:0] b);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= start;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    words_sent++;
  endtask

  // stop offering and wait for every predicted cell, then let the block settle
  task automatic drain_cells(input int settle);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (cells_owed != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // all three registers on back-to-back edges, block idle
  task automatic write_config(input logic rle, input logic lim_en,
                              input logic [CellCntW-1:0] lim);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_COMPRESSED;
    cfg_data  <= {{(CellCntW-1){1'b0}}, rle};
    @(posedge clk);
    cfg_index <= CFG_LIMIT_ENABLE;
    cfg_data  <= {{(CellCntW-1){1'b0}}, lim_en};
    @(posedge clk);
    cfg_index <= CFG_CELL_LIMIT;
    cfg_data  <= lim;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one well-formed run: code word then its operand words with random content
  task automatic send_run(input logic start);
    logic [1:0] k;
    logic [5:0] len;
    int         pick;
    k    = 2'($urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    if (k == KIND_BOTH) begin
      // both-repeated runs are cheap in words, so reach the full 64 cells
      if (pick < 60) len = 6'($urandom_range(0, 7));
      else if (pick < 90) len = 6'($urandom_range(8, 62));
      else len = 6'h3F;
    end else begin
      if (pick < 85) len = 6'($urandom_range(0, 5));
      else len = 6'($urandom_range(6, 15));
    end
    send_byte(start, {k, len});
    if (k == KIND_LIT) begin
      for (int i = 0; i <= len; i++) begin
        send_byte(rare_start(), rand_byte());
        send_byte(rare_start(), rand_byte());
      end
    end else if (k == KIND_BOTH) begin
      send_byte(rare_start(), rand_byte());
      send_byte(rare_start(), rand_byte());
    end else begin
      send_byte(rare_start(), rand_byte());
      for (int i = 0; i <= len; i++) send_byte(rare_start(), rand_byte());
    end
  endtask

  // mostly well-formed runs, some stray words, now and then a full pause
  task automatic send_runs(input int count, input int start_pct);
    int goal;
    int pick;
    goal = words_sent + count;
    while (words_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) drain_cells(0);
      else if (pick < 15) send_byte($urandom_range(0, 99) < 20, rand_byte());
      else send_run($urandom_range(0, 99) < start_pct);
    end
  endtask

  // plain mode: raw words, char then attribute
  task automatic send_pairs(input int count);
    for (int i = 0; i < count; i++) send_byte(i == 0 || rare_start(), rand_byte());
  endtask

  initial begin : stimulus
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_COMPRESSED;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed, compressed with no limit
    write_config(1'b1, 1'b0, '0);
    // literal run of two cells with extreme bytes
    send_byte(1'b1, {KIND_LIT, 6'd1});
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'h00);
    // repeated char, one cell
    send_byte(1'b0, {KIND_CHAR, 6'd0});
    send_byte(1'b0, 8'h7F);
    send_byte(1'b0, 8'h80);
    // repeated attribute, one cell
    send_byte(1'b0, {KIND_ATTR, 6'd0});
    send_byte(1'b0, 8'h0F);
    send_byte(1'b0, 8'hF0);
    // both repeated at full length, 64 cells from one word
    send_byte(1'b0, {KIND_BOTH, 6'h3F});
    send_byte(1'b0, 8'hAA);
    send_byte(1'b0, 8'h55);
    // start request in the middle of a literal run
    send_byte(1'b0, {KIND_LIT, 6'd5});
    send_byte(1'b0, 8'h12);
    send_byte(1'b1, {KIND_BOTH, 6'd2});
    send_byte(1'b0, 8'h34);
    send_byte(1'b0, 8'h56);
    drain_cells(SETTLE);

    // limit of three: a five-cell run still completes, the next code word is dropped
    write_config(1'b1, 1'b1, 32'd3);
    send_byte(1'b1, {KIND_BOTH, 6'd4});
    send_byte(1'b0, 8'h11);
    send_byte(1'b0, 8'h22);
    send_byte(1'b0, {KIND_LIT, 6'd0});
    drain_cells(SETTLE);

    // plain pairs cut at a small limit; odd word count leaves a pair half done
    write_config(1'b0, 1'b1, $urandom_range(4, 12));
    send_pairs(21);
    drain_cells(SETTLE);

    // compressed, limit off but at the top value, picked up from a half pair; no idling,
    // receiver holds off long so the block fills up and stalls its input
    gaps_on   = 1'b0;
    long_hold = 1'b1;
    write_config(1'b1, 1'b0, 32'hFFFF_FFFF);
    send_runs(20, 10);
    // stop inside a run to hand a half-done run to plain mode
    send_byte(1'b0, {KIND_CHAR, 6'd3});
    send_byte(1'b0, rand_byte());
    drain_cells(SETTLE);
    gaps_on = 1'b1;

    // plain mode, no limit
    write_config(1'b0, 1'b0, '0);
    send_pairs(16);
    drain_cells(SETTLE);

    // compressed, small limit, images restarted now and then
    write_config(1'b1, 1'b1, $urandom_range(10, 40));
    send_runs(25, 15);
    drain_cells(SETTLE);

    // zero limit: every code word is dropped
    write_config(1'b1, 1'b1, '0);
    for (int i = 0; i < 6; i++) send_byte(i == 0, rand_byte());
    drain_cells(SETTLE);

    // compressed, limit off but holding a random value
    write_config(1'b1, 1'b0, $urandom);
    send_runs(25, 10);
    drain_cells(SETTLE);

    if (mismatches == 0 && cells_owed == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
